FILE: rtl/rxpdr_pkg.sv
// Shared types and constants for the receive packet descriptor ring.
package rxpdr_pkg;

    // Default sizing of the ring and the receive data buffer
    localparam int DEF_DESC_COUNT = 16;
    localparam int DEF_DATA_SIZE  = 1024;
    localparam int DEF_MAX_PACKET = 133;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int LEN_W  = 8;

    // Operation codes; code 3 has no meaning and leaves the ring unchanged
    typedef enum logic [FUNC_W-1:0] {
        FUNC_COMMIT = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

endpackage

FILE: rtl/rxpdr_desc_mem.sv
// Descriptor store: one write port, one read port with registered read data.
module rxpdr_desc_mem #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4,
    parameter int DATA_W = 18
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rx_packet_descriptor_ring_core.sv
// Receive packet descriptor ring: commit, pop and clear of packet descriptors.
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  command   start, busy           i_func, i_recv_len, i_read_limit
//  result    o_valid (strobe)      o_next_addr, o_is_empty, o_pkt_start,
//                                  o_pkt_len, o_truncated
//
// One item is taken every cycle; busy is low whenever reset is released.
// Each result passes through the registered read port of the descriptor
// store, together with the stage 1 register, and then the result register.
// Reset clears the ring indices, the last packet end and the pipeline; the
// descriptor store itself is not cleared. The receiver cannot stall, so the
// pipeline never holds.
module rx_packet_descriptor_ring_core #(
    parameter int DESC_COUNT = rxpdr_pkg::DEF_DESC_COUNT,
    parameter int DATA_SIZE  = rxpdr_pkg::DEF_DATA_SIZE,
    parameter int MAX_PACKET = rxpdr_pkg::DEF_MAX_PACKET,
    localparam int ADDR_W    = $clog2(DATA_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rxpdr_pkg::FUNC_W-1:0] i_func,
    input  logic [rxpdr_pkg::LEN_W-1:0]  i_recv_len,
    input  logic [rxpdr_pkg::LEN_W-1:0]  i_read_limit,
    output logic                        o_valid,
    output logic [ADDR_W-1:0]           o_next_addr,
    output logic                        o_is_empty,
    output logic [ADDR_W-1:0]           o_pkt_start,
    output logic [rxpdr_pkg::LEN_W-1:0]  o_pkt_len,
    output logic                        o_truncated
);

    import rxpdr_pkg::*;

    localparam int IDX_W  = $clog2(DESC_COUNT);
    localparam int DESC_W = ADDR_W + LEN_W;

    // Highest offset that still leaves MAX_PACKET+1 bytes before the end
    localparam logic [ADDR_W-1:0] WRAP_LIMIT = ADDR_W'(DATA_SIZE - MAX_PACKET - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(MAX_PACKET);
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(DESC_COUNT - 1);

    typedef struct packed {
        logic valid;
        logic commit;
        logic pop;
        logic empty;
    } t_s1_ctrl;

    function automatic logic [IDX_W-1:0] f_next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] f_wrap(input logic [ADDR_W-1:0] p);
        return (p > WRAP_LIMIT) ? '0 : p;
    endfunction

    // Ring state
    logic [IDX_W-1:0]  r_write_idx, n_write_idx;
    logic [IDX_W-1:0]  r_read_idx,  n_read_idx;
    logic [ADDR_W-1:0] r_last_end,  n_last_end;

    // Stage 1
    t_s1_ctrl          r_s1, n_s1;
    logic [LEN_W-1:0]  r_s1_limit;
    logic [ADDR_W-1:0] r_s1_next;

    // Result register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_next_addr, n_next_addr;
    logic              r_is_empty,  n_is_empty;
    logic [ADDR_W-1:0] r_pkt_start, n_pkt_start;
    logic [LEN_W-1:0]  r_pkt_len,   n_pkt_len;
    logic              r_truncated, n_truncated;

    logic              accept;
    t_func             op;
    logic [LEN_W-1:0]  len_sat;
    logic [ADDR_W-1:0] commit_begin;
    logic [ADDR_W-1:0] commit_finish;
    logic [ADDR_W-1:0] commit_next;
    logic              ring_empty;
    logic              mem_wr_en;
    logic [DESC_W-1:0] mem_rd_data;
    logic [ADDR_W-1:0] rd_start;
    logic [LEN_W-1:0]  rd_len;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;
    assign op     = t_func'(i_func);

    // Commit placement: previous end, wrapped, plus the saturated length
    assign len_sat       = (i_recv_len > LEN_MAX) ? LEN_MAX : i_recv_len;
    assign commit_begin  = f_wrap(r_last_end);
    assign commit_finish = commit_begin + ADDR_W'(len_sat);
    assign commit_next   = f_wrap(commit_finish);
    assign ring_empty    = (r_read_idx == r_write_idx);

    // Decode of the accepted item
    always_comb begin
        n_write_idx = r_write_idx;
        n_read_idx  = r_read_idx;
        n_last_end  = r_last_end;
        mem_wr_en   = 1'b0;
        n_s1        = '0;
        n_s1.valid  = accept;
        if (accept) begin
            unique case (op)
                FUNC_COMMIT: begin
                    mem_wr_en   = 1'b1;
                    n_write_idx = f_next_idx(r_write_idx);
                    n_last_end  = commit_finish;
                    n_s1.commit = 1'b1;
                end
                FUNC_READ: begin
                    if (ring_empty) begin
                        n_s1.empty = 1'b1;
                    end else begin
                        n_s1.pop   = 1'b1;
                        n_read_idx = f_next_idx(r_read_idx);
                    end
                end
                FUNC_CLEAR: begin
                    n_read_idx = r_write_idx;
                end
                default: begin
                end
            endcase
        end
    end

    // Descriptor store holds start offset and saturated length
    rxpdr_desc_mem #(
        .DEPTH  (DESC_COUNT),
        .IDX_W  (IDX_W),
        .DATA_W (DESC_W)
    ) u_desc_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_write_idx),
        .i_wr_data ({commit_begin, len_sat}),
        .i_rd_addr (r_read_idx),
        .o_rd_data (mem_rd_data)
    );

    assign rd_start = mem_rd_data[DESC_W-1:LEN_W];
    assign rd_len   = mem_rd_data[LEN_W-1:0];

    // Result fields; unused fields are zero
    always_comb begin
        n_next_addr = r_s1.commit ? r_s1_next : '0;
        n_is_empty  = r_s1.empty;
        n_pkt_start = '0;
        n_pkt_len   = '0;
        n_truncated = 1'b0;
        if (r_s1.pop) begin
            n_pkt_start = rd_start;
            if (rd_len > r_s1_limit) begin
                n_pkt_len   = r_s1_limit;
                n_truncated = 1'b1;
            end else begin
                n_pkt_len   = rd_len;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_idx <= '0;
            r_read_idx  <= '0;
            r_last_end  <= '0;
            r_s1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_write_idx <= n_write_idx;
            r_read_idx  <= n_read_idx;
            r_last_end  <= n_last_end;
            r_s1        <= n_s1;
            r_out_valid <= r_s1.valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s1_limit  <= i_read_limit;
        r_s1_next   <= commit_next;
        r_next_addr <= n_next_addr;
        r_is_empty  <= n_is_empty;
        r_pkt_start <= n_pkt_start;
        r_pkt_len   <= n_pkt_len;
        r_truncated <= n_truncated;
    end

    assign o_valid     = r_out_valid;
    assign o_next_addr = r_next_addr;
    assign o_is_empty  = r_is_empty;
    assign o_pkt_start = r_pkt_start;
    assign o_pkt_len   = r_pkt_len;
    assign o_truncated = r_truncated;

endmodule

FILE: rtl/rxpdr_checker.sv
// Port-level checks for the descriptor ring, bound to the top level.
module rxpdr_checker #(
    parameter int ADDR_W = $clog2(rxpdr_pkg::DEF_DATA_SIZE)
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [rxpdr_pkg::FUNC_W-1:0] i_func,
    input logic [rxpdr_pkg::LEN_W-1:0]  i_read_limit,
    input logic                        o_valid,
    input logic                        o_is_empty,
    input logic [ADDR_W-1:0]           o_pkt_start,
    input logic [rxpdr_pkg::LEN_W-1:0]  o_pkt_len,
    input logic                        o_truncated
);

    import rxpdr_pkg::*;

    // Every accepted item gives a result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted item gave no result");

    // No strobe without an accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    // A commit result carries only the next receive address
    a_commit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_func, 2) == FUNC_COMMIT) |->
        (!o_is_empty && o_pkt_start == '0 && o_pkt_len == '0 && !o_truncated))
        else $error("commit result has read fields set");

    // A clipped length equals the reader's limit of that item
    a_trunc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_truncated) |->
        (o_pkt_len == $past(i_read_limit, 2) && $past(i_func, 2) == FUNC_READ))
        else $error("truncated length differs from read limit");

endmodule

bind rx_packet_descriptor_ring_core rxpdr_checker #(.ADDR_W(ADDR_W)) u_rxpdr_checker (.*);
